// ===== rtl/per_class_box_nms_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the per-class box NMS datapath
// Clock clk and reset arst_n are taken from the including module.
// ----------------------------------------------------------------------------
`ifndef PER_CLASS_BOX_NMS_MACROS_SVH
`define PER_CLASS_BOX_NMS_MACROS_SVH

// Condition that holds at every clock edge out of reset
`define PCBN_CHECK(lbl, expr, msg) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) (expr)) else $error(msg);

// Condition that holds in the cycle after a trigger
`define PCBN_CHECK_NEXT(lbl, pre, post, msg) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/pcbn_pkg.sv =====
// ----------------------------------------------------------------------------
// pcbn_pkg
// Types, constants and controller codes of the per-class box NMS block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcbn_pkg;

	// Capacity and field widths
	localparam int MAX_DET     = 64;
	localparam int IDX_W       = $clog2(MAX_DET);
	localparam int CNT_W       = IDX_W + 1;
	localparam int NUM_CLASSES = 80;
	localparam int CLS_W       = 7;
	localparam int SCORE_W     = 16;
	localparam int COORD_W     = 16;
	localparam int THR_W       = 16;
	localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

	// Stored words: box = {h, w, cy, cx}, tag = {class, score}
	localparam int BOX_W = 4 * COORD_W;
	localparam int TAG_W = CLS_W + SCORE_W;
	// Ordering key = {class, inverted score, index}
	localparam int KEY_W = TAG_W + IDX_W;

	// Overlap arithmetic
	localparam int EDGE_W  = COORD_W + 3;
	localparam int SPAN_W  = COORD_W + 2;
	localparam int AREA_W  = 2 * COORD_W;
	localparam int INTER_W = 2 * SPAN_W;
	localparam int UNI_W   = INTER_W + 2;
	localparam int LO_W    = 19;
	localparam int HI_W    = UNI_W - 1 - LO_W;
	localparam int PLO_W   = THR_W + LO_W;
	localparam int PHI_W   = THR_W + HI_W;
	localparam int PROD_W  = PHI_W + LO_W + 1;

	// Configuration port
	localparam int APB_AW = 3;
	localparam logic REG_THR = 1'b0;

	typedef struct packed {
		logic [CLS_W-1:0]          class_id;
		logic [SCORE_W-1:0]        score;
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic [COORD_W-1:0]        box_width;
		logic [COORD_W-1:0]        box_height;
		logic                      last;
	} det_t;

	typedef struct packed {
		logic [CLS_W-1:0]          out_class;
		logic [SCORE_W-1:0]        out_score;
		logic signed [COORD_W-1:0] out_center_x;
		logic signed [COORD_W-1:0] out_center_y;
		logic [COORD_W-1:0]        out_width;
		logic [COORD_W-1:0]        out_height;
		logic                      end_of_set;
		logic                      dropped;
	} res_t;

	typedef enum logic [3:0] {
		S_LOAD, S_SEL, S_SEL_END, S_DECIDE, S_FETCH,
		S_FETCH_W, S_CHK, S_CHK_END, S_KEEP, S_FLUSH
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic scan_clr;
		logic sel_issue;
		logic fetch;
		logic capture;
		logic chk_issue;
		logic keep;
		logic emit_last;
		logic finish;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic closing;
		logic scan_end;
		logic sel_busy;
		logic found;
		logic chk_busy;
		logic suppressed;
		logic out_free;
		logic have_pend;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/per_class_box_nms.sv =====
// ----------------------------------------------------------------------------
// per_class_box_nms
// Per-class greedy non-maximum suppression over a set of up to 64 boxes.
//
// Detections enter on det (valid/ready); the item with last set closes the
// set. Items with an out-of-range class are discarded; items past capacity
// are discarded and mark every result of the set as dropped. Loading accepts
// one item per cycle. After the closing transfer the block emits the kept
// boxes on res (valid/ready), class ascending, score descending, ties in
// input order, end_of_set on the last one; an empty set emits nothing.
// For n stored boxes each box costs one ordering scan and one overlap scan
// over the stores, and each kept box of its class passes through the six-stage
// overlap unit; det_ready stays low until the set is processed. Results
// travel through one output register: a stall on res holds the sequencer,
// and a new set may start loading while the final result still waits.
// Reset clears the stored count, flags and threshold (29491) at once; no
// clearing pass. overlap_threshold is written over APB at address 0.
// ----------------------------------------------------------------------------
`default_nettype none

module per_class_box_nms import pcbn_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire det_t              det,
	input  wire logic              det_valid,
	output logic                   det_ready,
	output res_t                   res,
	output logic                   res_valid,
	input  wire logic              res_ready,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	logic [THR_W-1:0] thr_q;
	logic             reg_hit;
	cmd_t             cmd;
	sts_t             sts;

	// Configuration register
	assign pready  = 1'b1;
	assign reg_hit = (paddr[APB_AW-1] == REG_THR);
	assign prdata  = reg_hit ? {{(32 - THR_W){1'b0}}, thr_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	pcbn_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	pcbn_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.det       (det),
		.det_valid (det_valid),
		.det_ready (det_ready),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.thr       (thr_q)
	);

endmodule

`default_nettype wire

// ===== rtl/pcbn_ram.sv =====
// ----------------------------------------------------------------------------
// pcbn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pcbn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/pcbn_iou.sv =====
// ----------------------------------------------------------------------------
// pcbn_iou
// Six-stage overlap test: flags a kept box a whose IoU with candidate b
// exceeds the threshold, as inter * 2^16 > thr * union on doubled edges.
// ----------------------------------------------------------------------------
`default_nettype none

module pcbn_iou import pcbn_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_vld,
	input  wire logic [BOX_W-1:0] a_box,
	input  wire logic [BOX_W-1:0] b_box,
	input  wire logic [THR_W-1:0] thr,
	output logic                  busy,
	output logic                  hit
);

	logic signed [EDGE_W-1:0] cxa2, cya2, cxb2, cyb2, wa_e, ha_e, wb_e, hb_e;
	logic signed [EDGE_W-1:0] la, ra, ta, da, lb, rb, tb, db;
	logic signed [EDGE_W-1:0] l_s1, r_s1, t_s1, d_s1;
	logic [COORD_W-1:0]       wa_s1, ha_s1, wa_s2, ha_s2, wb, hb;
	logic [SPAN_W-1:0]        dx_s2, dy_s2;
	logic                     ok_s2;
	logic [INTER_W-1:0]       inter_s3, inter_s4, inter_s5;
	logic [AREA_W-1:0]        aa_s3, ab_s3;
	logic signed [UNI_W-1:0]  uni_c;
	logic [UNI_W-2:0]         unim_s4;
	logic                     pos_s4;
	logic [PLO_W-1:0]         plo_s5;
	logic [PHI_W-1:0]         phi_s5;
	logic [PROD_W-1:0]        prod, lhs;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, hit_s6;

	// Doubled centers and extents
	assign cxa2 = EDGE_W'({{2{a_box[COORD_W-1]}}, a_box[COORD_W-1:0], 1'b0});
	assign cya2 = EDGE_W'({{2{a_box[2*COORD_W-1]}}, a_box[2*COORD_W-1:COORD_W], 1'b0});
	assign cxb2 = EDGE_W'({{2{b_box[COORD_W-1]}}, b_box[COORD_W-1:0], 1'b0});
	assign cyb2 = EDGE_W'({{2{b_box[2*COORD_W-1]}}, b_box[2*COORD_W-1:COORD_W], 1'b0});
	assign wa_e = EDGE_W'({3'b000, a_box[3*COORD_W-1:2*COORD_W]});
	assign ha_e = EDGE_W'({3'b000, a_box[4*COORD_W-1:3*COORD_W]});
	assign wb_e = EDGE_W'({3'b000, b_box[3*COORD_W-1:2*COORD_W]});
	assign hb_e = EDGE_W'({3'b000, b_box[4*COORD_W-1:3*COORD_W]});
	assign wb   = b_box[3*COORD_W-1:2*COORD_W];
	assign hb   = b_box[4*COORD_W-1:3*COORD_W];

	assign la = cxa2 - wa_e;
	assign ra = cxa2 + wa_e;
	assign ta = cya2 - ha_e;
	assign da = cya2 + ha_e;
	assign lb = cxb2 - wb_e;
	assign rb = cxb2 + wb_e;
	assign tb = cyb2 - hb_e;
	assign db = cyb2 + hb_e;

	// Union minus intersection, four times the areas
	assign uni_c = $signed(UNI_W'({aa_s3, 2'b00})) + $signed(UNI_W'({ab_s3, 2'b00}))
		- $signed(UNI_W'(inter_s3));

	// Final compare operands
	assign prod = PROD_W'(plo_s5) + (PROD_W'(phi_s5) << LO_W);
	assign lhs  = PROD_W'({inter_s5, 16'h0000});

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			hit_s6 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2 & ok_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4 & pos_s4;
			vld_s6 <= vld_s5;
			hit_s6 <= vld_s5 & (lhs > prod);
		end
	end

	// Arithmetic stages
	always_ff @(posedge clk) begin
		// intersection edges
		l_s1  <= (lb > la) ? lb : la;
		r_s1  <= (rb < ra) ? rb : ra;
		t_s1  <= (tb > ta) ? tb : ta;
		d_s1  <= (db < da) ? db : da;
		wa_s1 <= a_box[3*COORD_W-1:2*COORD_W];
		ha_s1 <= a_box[4*COORD_W-1:3*COORD_W];
		// spans
		ok_s2 <= (l_s1 <= r_s1) && (t_s1 <= d_s1);
		dx_s2 <= SPAN_W'(r_s1 - l_s1);
		dy_s2 <= SPAN_W'(d_s1 - t_s1);
		wa_s2 <= wa_s1;
		ha_s2 <= ha_s1;
		// products
		inter_s3 <= dx_s2 * dy_s2;
		aa_s3    <= wa_s2 * ha_s2;
		ab_s3    <= wb * hb;
		// union
		inter_s4 <= inter_s3;
		unim_s4  <= uni_c[UNI_W-2:0];
		pos_s4   <= !uni_c[UNI_W-1] && (uni_c != '0);
		// threshold times union, two partial products
		inter_s5 <= inter_s4;
		plo_s5   <= thr * unim_s4[LO_W-1:0];
		phi_s5   <= thr * unim_s4[UNI_W-2:LO_W];
	end

	assign busy = vld_s1 | vld_s2 | vld_s3 | vld_s4 | vld_s5 | vld_s6;
	assign hit  = hit_s6;

endmodule

`default_nettype wire

// ===== rtl/pcbn_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcbn_ctrl
// Sequencer: load, select next box in order, check against kept boxes,
// keep or drop it, and flush the held result at the end of the set.
// ----------------------------------------------------------------------------
`default_nettype none

module pcbn_ctrl import pcbn_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			S_LOAD: begin
				cmd.load     = 1'b1;
				cmd.scan_clr = 1'b1;
				if (sts.closing) state_nxt = S_SEL;
			end
			S_SEL: begin
				cmd.sel_issue = 1'b1;
				if (sts.scan_end) state_nxt = S_SEL_END;
			end
			S_SEL_END: begin
				if (!sts.sel_busy) state_nxt = S_DECIDE;
			end
			S_DECIDE: begin
				state_nxt = sts.found ? S_FETCH : S_FLUSH;
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_nxt = S_FETCH_W;
			end
			S_FETCH_W: begin
				cmd.capture  = 1'b1;
				cmd.scan_clr = 1'b1;
				state_nxt    = S_CHK;
			end
			S_CHK: begin
				cmd.chk_issue = 1'b1;
				if (sts.scan_end) state_nxt = S_CHK_END;
			end
			S_CHK_END: begin
				if (!sts.chk_busy) state_nxt = S_KEEP;
			end
			S_KEEP: begin
				if (sts.suppressed) begin
					cmd.scan_clr = 1'b1;
					state_nxt    = S_SEL;
				end else if (!sts.have_pend || sts.out_free) begin
					cmd.keep     = 1'b1;
					cmd.scan_clr = 1'b1;
					state_nxt    = S_SEL;
				end
			end
			S_FLUSH: begin
				if (!sts.have_pend || sts.out_free) begin
					cmd.emit_last = 1'b1;
					cmd.finish    = 1'b1;
					state_nxt     = S_LOAD;
				end
			end
			default: state_nxt = S_LOAD;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/pcbn_dp.sv =====
// ----------------------------------------------------------------------------
// pcbn_dp
// Datapath: detection stores, ordering scan, overlap unit, held result
// and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "per_class_box_nms_macros.svh"

module pcbn_dp import pcbn_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cmd_t             cmd,
	output sts_t                  sts,
	input  wire det_t             det,
	input  wire logic             det_valid,
	output logic                  det_ready,
	output res_t                  res,
	output logic                  res_valid,
	input  wire logic             res_ready,
	input  wire logic [THR_W-1:0] thr
);

	logic [CNT_W-1:0]   cnt_q, scan_q;
	logic               ovf_q;
	logic               acc, cls_ok, room, store, scan_end, issue, better, emit;
	logic [IDX_W-1:0]   box_raddr, idx_s1;
	logic [BOX_W-1:0]   wr_box, box_rd, cand_box_q, pend_box_q;
	logic [TAG_W-1:0]   wr_tag, tag_rd, cand_tag_q, pend_tag_q;
	logic [IDX_W-1:0]   cand_idx_q;
	logic [KEY_W-1:0]   key_s1, best_key_q, prev_key_q;
	logic               sel_vld_s1, chk_vld_s1, found_q, prev_vld_q, sup_q;
	logic               have_pend_q, out_vld_q, chk_in, iou_busy, iou_hit;
	logic [MAX_DET-1:0] kept_q;
	res_t               out_q;

	// Input side
	assign det_ready = cmd.load;
	assign acc    = det_valid & cmd.load;
	assign cls_ok = {1'b0, det.class_id} < (CLS_W + 1)'(NUM_CLASSES);
	assign room   = cnt_q < CNT_W'(MAX_DET);
	assign store  = acc & cls_ok & room;
	assign wr_box = {det.box_height, det.box_width, det.center_y, det.center_x};
	assign wr_tag = {det.class_id, det.score};

	// Scan addressing
	assign scan_end  = (scan_q == cnt_q);
	assign issue     = (cmd.sel_issue | cmd.chk_issue) & ~scan_end;
	assign box_raddr = cmd.fetch ? best_key_q[IDX_W-1:0] : scan_q[IDX_W-1:0];

	pcbn_ram #(.WIDTH(BOX_W), .DEPTH(MAX_DET)) u_box_ram (
		.clk   (clk),
		.we    (store),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata (wr_box),
		.raddr (box_raddr),
		.rdata (box_rd)
	);

	pcbn_ram #(.WIDTH(TAG_W), .DEPTH(MAX_DET)) u_tag_ram (
		.clk   (clk),
		.we    (store),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata (wr_tag),
		.raddr (scan_q[IDX_W-1:0]),
		.rdata (tag_rd)
	);

	// Next-in-order search: smallest key above the last one taken
	assign key_s1 = {tag_rd[TAG_W-1 -: CLS_W], ~tag_rd[SCORE_W-1:0], idx_s1};
	assign better = (!prev_vld_q || key_s1 > prev_key_q) && (!found_q || key_s1 < best_key_q);

	// Kept box of the candidate's class goes to the overlap unit
	assign chk_in = chk_vld_s1 && kept_q[idx_s1]
		&& (tag_rd[TAG_W-1 -: CLS_W] == cand_tag_q[TAG_W-1 -: CLS_W]);

	pcbn_iou u_iou (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (chk_in),
		.a_box  (box_rd),
		.b_box  (cand_box_q),
		.thr    (thr),
		.busy   (iou_busy),
		.hit    (iou_hit)
	);

	assign emit = (cmd.keep | cmd.emit_last) & have_pend_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			scan_q      <= '0;
			sel_vld_s1  <= 1'b0;
			chk_vld_s1  <= 1'b0;
			found_q     <= 1'b0;
			prev_vld_q  <= 1'b0;
			sup_q       <= 1'b0;
			kept_q      <= '0;
			have_pend_q <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (store) cnt_q <= cnt_q + 1'b1;
			if (acc & cls_ok & ~room) ovf_q <= 1'b1;
			if (cmd.scan_clr) begin
				scan_q <= '0;
			end else if (issue) begin
				scan_q <= scan_q + 1'b1;
			end
			sel_vld_s1 <= cmd.sel_issue & ~scan_end;
			chk_vld_s1 <= cmd.chk_issue & ~scan_end;
			if (cmd.scan_clr && !cmd.capture) begin
				found_q <= 1'b0;
			end else if (sel_vld_s1 && better) begin
				found_q <= 1'b1;
			end
			if (cmd.fetch) prev_vld_q <= 1'b1;
			if (cmd.capture) begin
				sup_q <= 1'b0;
			end else if (iou_hit) begin
				sup_q <= 1'b1;
			end
			if (cmd.keep) begin
				kept_q[cand_idx_q] <= 1'b1;
				have_pend_q        <= 1'b1;
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (res_ready) begin
				out_vld_q <= 1'b0;
			end
			if (cmd.finish) begin
				cnt_q       <= '0;
				ovf_q       <= 1'b0;
				kept_q      <= '0;
				prev_vld_q  <= 1'b0;
				have_pend_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= scan_q[IDX_W-1:0];
		if (sel_vld_s1 && better) best_key_q <= key_s1;
		if (cmd.fetch) begin
			prev_key_q <= best_key_q;
			cand_idx_q <= best_key_q[IDX_W-1:0];
			cand_tag_q <= {best_key_q[KEY_W-1 -: CLS_W], ~best_key_q[IDX_W +: SCORE_W]};
		end
		if (cmd.capture) cand_box_q <= box_rd;
		if (cmd.keep) begin
			pend_tag_q <= cand_tag_q;
			pend_box_q <= cand_box_q;
		end
		if (emit) begin
			out_q.out_class    <= pend_tag_q[TAG_W-1 -: CLS_W];
			out_q.out_score    <= pend_tag_q[SCORE_W-1:0];
			out_q.out_center_x <= pend_box_q[COORD_W-1:0];
			out_q.out_center_y <= pend_box_q[2*COORD_W-1:COORD_W];
			out_q.out_width    <= pend_box_q[3*COORD_W-1:2*COORD_W];
			out_q.out_height   <= pend_box_q[4*COORD_W-1:3*COORD_W];
			out_q.end_of_set   <= cmd.emit_last;
			out_q.dropped      <= ovf_q;
		end
	end

	assign res       = out_q;
	assign res_valid = out_vld_q;

	// Status
	always_comb begin
		sts            = '0;
		sts.closing    = acc & det.last;
		sts.scan_end   = scan_end;
		sts.sel_busy   = sel_vld_s1;
		sts.found      = found_q;
		sts.chk_busy   = chk_vld_s1 | iou_busy;
		sts.suppressed = sup_q;
		sts.out_free   = ~out_vld_q | res_ready;
		sts.have_pend  = have_pend_q;
	end

	`PCBN_CHECK(a_cnt_range, cnt_q <= CNT_W'(MAX_DET), "loaded count beyond capacity")
	`PCBN_CHECK(a_keep_clean, !cmd.keep || !sup_q, "suppressed box committed")
	`PCBN_CHECK(a_emit_free, !emit || !out_vld_q || res_ready, "pending result overwritten")
	`PCBN_CHECK_NEXT(a_finish, cmd.finish, (cnt_q == '0) && !have_pend_q && (kept_q == '0), "set not cleared")

endmodule

`default_nettype wire
